@@ rtl/srcc_pkg.sv @@
// Shared types and constants for the seed rectangle conflict checker.
package srcc_pkg;

  localparam int COORD_W = 9;
  localparam int EPOCH_W = 3;
  localparam int LBL_W   = 2;
  localparam int WORD_W  = EPOCH_W + LBL_W;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_RECT  = 2'd1;
  localparam logic [1:0] FUNC_MASK  = 2'd2;
  localparam logic [1:0] FUNC_FIN   = 2'd3;

  localparam logic [2:0] CODE_OK       = 3'd0;
  localparam logic [2:0] CODE_OOB      = 3'd1;
  localparam logic [2:0] CODE_CONFLICT = 3'd2;
  localparam logic [2:0] CODE_NO_BG    = 3'd3;
  localparam logic [2:0] CODE_NO_OBJ   = 3'd4;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OOB      = 2'd1;
  localparam logic [1:0] ERR_CONFLICT = 2'd2;

  localparam logic [LBL_W-1:0] LBL_NONE = 2'd0;
  localparam logic [LBL_W-1:0] LBL_BG   = 2'd1;
  localparam logic [LBL_W-1:0] LBL_OBJ  = 2'd2;

  localparam logic [1:0] CFG_IMAGE_W = 2'd0;
  localparam logic [1:0] CFG_IMAGE_H = 2'd1;
  localparam logic [1:0] CFG_MASK_W  = 2'd2;
  localparam logic [1:0] CFG_MASK_H  = 2'd3;

  typedef struct packed {
    logic       accept;
    logic [1:0] func;
    logic       paint_rd;
    logic       paint_wr;
    logic       mask_eval;
    logic       clr_step;
    logic       load_out;
    logic       load_fin;
  } srcc_cmd_t;

  typedef struct packed {
    logic rect_go;
    logic pix_last;
    logic epoch_wrap;
    logic clr_last;
  } srcc_sts_t;

endpackage

@@ rtl/srcc_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module srcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/srcc_ctrl.sv @@
// Sequencing state machine for the seed rectangle conflict checker.
module srcc_ctrl
  import srcc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_func,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  srcc_sts_t sts,
  output srcc_cmd_t cmd
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_PRD  = 3'd2;
  localparam logic [2:0] ST_PWR  = 3'd3;
  localparam logic [2:0] ST_MASK = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.accept    = accept;
    cmd.func      = in_func;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FUNC_START: begin
              cmd.load_out = 1'b1;
              if (sts.epoch_wrap) begin
                state_nxt = ST_CLR;
              end
            end
            FUNC_RECT: begin
              if (sts.rect_go) begin
                state_nxt = ST_PRD;
              end else begin
                cmd.load_out = 1'b1;
              end
            end
            FUNC_MASK: begin
              state_nxt = ST_MASK;
            end
            FUNC_FIN: begin
              cmd.load_out = 1'b1;
              cmd.load_fin = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_PRD: begin
        cmd.paint_rd = 1'b1;
        state_nxt    = ST_PWR;
      end
      ST_PWR: begin
        cmd.paint_wr = 1'b1;
        if (sts.pix_last) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_PRD;
        end
      end
      ST_MASK: begin
        cmd.mask_eval = 1'b1;
        cmd.load_out  = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/srcc_dp.sv @@
// Datapath: configuration, bounds check, label store, flags and result word.
module srcc_dp
  import srcc_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  input  logic signed [15:0]   in_rect_x,
  input  logic signed [15:0]   in_rect_y,
  input  logic signed [15:0]   in_rect_width,
  input  logic signed [15:0]   in_rect_height,
  input  logic                 in_rect_label,
  input  logic [7:0]           in_pixel_row,
  input  logic [7:0]           in_pixel_column,
  input  logic [1:0]           in_mask_label,
  input  srcc_cmd_t            cmd,
  output srcc_sts_t            sts,
  output logic [2:0]           out_status_code,
  output logic                 out_verdict
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW    = CW + RW;
  localparam int DEPTH = 1 << AW;

  logic [COORD_W-1:0] img_w_r, img_h_r, msk_w_r, msk_h_r;
  logic [COORD_W-1:0] eff_w, eff_h;
  logic [1:0]         fe_r, fe_nxt;
  logic               bg_r, bg_nxt, obj_r, obj_nxt;
  logic [EPOCH_W-1:0] epoch_r;
  logic [AW-1:0]      clr_cnt_r;
  logic [COORD_W-1:0] col_r, row_r, x0_r, col_end_r, row_end_r;
  logic [LBL_W-1:0]   lab_r;
  logic               mask_ok_r;
  logic [LBL_W-1:0]   mask_lab_r;
  logic [2:0]         out_code_r;
  logic               out_verdict_r;
  logic [15:0]        x_sum, y_sum;
  logic               bounds_ok, mask_ok, mask_present;
  logic               start_acc, rect_acc, mask_acc;
  logic [WORD_W-1:0]  rd_word, wr_word;
  logic [LBL_W-1:0]   cur_lab;
  logic [AW-1:0]      paint_addr, mask_addr, raddr, waddr;
  logic               we, re;
  logic [2:0]         fin_code;

  assign start_acc = cmd.accept && (cmd.func == FUNC_START);
  assign rect_acc  = cmd.accept && (cmd.func == FUNC_RECT);
  assign mask_acc  = cmd.accept && (cmd.func == FUNC_MASK);

  assign eff_w = ({7'd0, img_w_r} > 16'(MAX_WIDTH))  ? COORD_W'(MAX_WIDTH)  : img_w_r;
  assign eff_h = ({7'd0, img_h_r} > 16'(MAX_HEIGHT)) ? COORD_W'(MAX_HEIGHT) : img_h_r;

  assign x_sum = {1'b0, in_rect_x[14:0]} + {1'b0, in_rect_width[14:0]};
  assign y_sum = {1'b0, in_rect_y[14:0]} + {1'b0, in_rect_height[14:0]};

  assign bounds_ok = !in_rect_width[15] && (in_rect_width != 16'sd0)
                  && !in_rect_height[15] && (in_rect_height != 16'sd0)
                  && !in_rect_x[15] && !in_rect_y[15]
                  && (x_sum <= {7'd0, eff_w}) && (y_sum <= {7'd0, eff_h});

  assign mask_present = (msk_w_r != '0) && (msk_h_r != '0);
  assign mask_ok = mask_present
                && ({1'b0, in_pixel_row} < msk_h_r) && ({1'b0, in_pixel_column} < msk_w_r)
                && ({1'b0, in_pixel_row} < eff_h) && ({1'b0, in_pixel_column} < eff_w)
                && ((in_mask_label == LBL_BG) || (in_mask_label == LBL_OBJ));

  assign sts.rect_go    = bounds_ok && (fe_r == ERR_NONE);
  assign sts.pix_last   = (col_r == col_end_r) && (row_r == row_end_r);
  assign sts.epoch_wrap = &epoch_r;
  assign sts.clr_last   = &clr_cnt_r;

  assign paint_addr = {RW'(row_r), CW'(col_r)};
  assign mask_addr  = {RW'(in_pixel_row), CW'(in_pixel_column)};

  assign cur_lab = (rd_word[WORD_W-1:LBL_W] == epoch_r) ? rd_word[LBL_W-1:0] : LBL_NONE;

  assign re    = mask_acc || cmd.paint_rd;
  assign raddr = cmd.paint_rd ? paint_addr : mask_addr;
  assign we    = cmd.clr_step || (cmd.paint_wr && (cur_lab == LBL_NONE));
  assign waddr = cmd.clr_step ? clr_cnt_r : paint_addr;
  assign wr_word = cmd.clr_step ? '0 : {epoch_r, lab_r};

  srcc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_label_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_word),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_word)
  );

  always_comb begin
    fe_nxt  = fe_r;
    bg_nxt  = bg_r;
    obj_nxt = obj_r;
    if (start_acc) begin
      fe_nxt  = ERR_NONE;
      bg_nxt  = 1'b0;
      obj_nxt = 1'b0;
    end else if (rect_acc && (fe_r == ERR_NONE)) begin
      if (!bounds_ok) begin
        fe_nxt = ERR_OOB;
      end else if (in_rect_label) begin
        obj_nxt = 1'b1;
      end else begin
        bg_nxt = 1'b1;
      end
    end else if (cmd.paint_wr) begin
      if ((cur_lab != LBL_NONE) && (cur_lab != lab_r) && (fe_r == ERR_NONE)) begin
        fe_nxt = ERR_CONFLICT;
      end
    end else if (cmd.mask_eval && mask_ok_r && (cur_lab == LBL_NONE)) begin
      if (mask_lab_r == LBL_BG) begin
        bg_nxt = 1'b1;
      end else begin
        obj_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    if (mask_present && ((msk_w_r != img_w_r) || (msk_h_r != img_h_r))) begin
      fin_code = CODE_OOB;
    end else if (fe_r != ERR_NONE) begin
      fin_code = {1'b0, fe_r};
    end else if (!bg_r) begin
      fin_code = CODE_NO_BG;
    end else if (!obj_r) begin
      fin_code = CODE_NO_OBJ;
    end else begin
      fin_code = CODE_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r   <= COORD_W'(256);
      img_h_r   <= COORD_W'(256);
      msk_w_r   <= '0;
      msk_h_r   <= '0;
      fe_r      <= ERR_NONE;
      bg_r      <= 1'b0;
      obj_r     <= 1'b0;
      epoch_r   <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IMAGE_W: img_w_r <= cfg_data;
          CFG_IMAGE_H: img_h_r <= cfg_data;
          CFG_MASK_W:  msk_w_r <= cfg_data;
          CFG_MASK_H:  msk_h_r <= cfg_data;
          default: ;
        endcase
      end
      fe_r  <= fe_nxt;
      bg_r  <= bg_nxt;
      obj_r <= obj_nxt;
      if (start_acc) begin
        epoch_r <= epoch_r + 1'b1;
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rect_acc) begin
      x0_r      <= in_rect_x[COORD_W-1:0];
      col_r     <= in_rect_x[COORD_W-1:0];
      row_r     <= in_rect_y[COORD_W-1:0];
      col_end_r <= COORD_W'(x_sum - 16'd1);
      row_end_r <= COORD_W'(y_sum - 16'd1);
      lab_r     <= in_rect_label ? LBL_OBJ : LBL_BG;
    end else if (cmd.paint_wr) begin
      if (col_r == col_end_r) begin
        col_r <= x0_r;
        row_r <= row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
    if (mask_acc) begin
      mask_ok_r  <= mask_ok;
      mask_lab_r <= in_mask_label;
    end
    if (cmd.load_out) begin
      out_verdict_r <= cmd.load_fin;
      out_code_r    <= cmd.load_fin ? fin_code : {1'b0, fe_nxt};
    end
  end

  assign out_status_code = out_code_r;
  assign out_verdict     = out_verdict_r;

endmodule

@@ rtl/seed_rectangle_conflict_checker_unit.sv @@
// Seed rectangle conflict checker: top level joining the controller and the datapath.
//
// Input words carry a function code and the fields of a seed rectangle or a mask pixel.
// A word is taken when in_valid is high and in_stall is low; every word returns exactly
// one result word on the out_ channel, taken when out_valid is high and out_stall low.
// Start, finish and rejected or skipped rectangles give their result the cycle after
// acceptance, so one such word per cycle is sustained while out_stall is low and no
// clearing pass is due. A mask pixel needs one read of the label RAM. A painted rectangle
// is walked pixel by pixel, each pixel a read followed by a write on the single label RAM.
// The label RAM entries carry an epoch mark, so a start word does not touch the RAM;
// after reset, and on every eighth start, a clearing pass writes all
// MAX_HEIGHT_P2 * MAX_WIDTH_P2 entries (65536 at the default size, dimensions
// rounded up to powers of two) while in_stall stays high.
// Configuration writes through cfg_we, cfg_index and cfg_data are accepted at any time
// and should only be issued while the block is idle.
// A result held under out_stall stays stable, and the block accepts a further word while
// it is waiting only if the pending result is taken in the same cycle.
module seed_rectangle_conflict_checker_unit
  import srcc_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [COORD_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [15:0] in_rect_x,
  input  logic signed [15:0] in_rect_y,
  input  logic signed [15:0] in_rect_width,
  input  logic signed [15:0] in_rect_height,
  input  logic               in_rect_label,
  input  logic [7:0]         in_pixel_row,
  input  logic [7:0]         in_pixel_column,
  input  logic [1:0]         in_mask_label,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status_code,
  output logic               out_verdict
);

  srcc_cmd_t cmd;
  srcc_sts_t sts;

  srcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  srcc_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_rect_x       (in_rect_x),
    .in_rect_y       (in_rect_y),
    .in_rect_width   (in_rect_width),
    .in_rect_height  (in_rect_height),
    .in_rect_label   (in_rect_label),
    .in_pixel_row    (in_pixel_row),
    .in_pixel_column (in_pixel_column),
    .in_mask_label   (in_mask_label),
    .cmd             (cmd),
    .sts             (sts),
    .out_status_code (out_status_code),
    .out_verdict     (out_verdict)
  );

  a_fin_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == FUNC_FIN) |=> out_valid && out_verdict)
    else $error("finish word did not return a verdict in the next cycle");

  a_start_ok: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == FUNC_START)
    |=> out_valid && !out_verdict && (out_status_code == CODE_OK))
    else $error("start word did not return a clean status in the next cycle");

  a_sticky_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_verdict
    |-> (out_status_code == CODE_OK) || (out_status_code == CODE_OOB)
        || (out_status_code == CODE_CONFLICT))
    else $error("non-finish result carries a finish-only status code");

  a_busy_paint: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.paint_rd |=> in_stall && !out_valid)
    else $error("word accepted or result shown in the middle of painting");

endmodule
